// ----- rtl/kwm_pkg.sv -----
// Shared types and constants for the k-way run merge unit.
// Used by every module under rtl/ except kwm_ram; depends on nothing.
package kwm_pkg;

  localparam int WAYS  = 8;
  localparam int BLOCK = 16;

  localparam int OP_W    = 2;
  localparam int RUN_W   = 3;
  localparam int SLOT_W  = 4;
  localparam int VAL_W   = 64;
  localparam int POS_W   = 32;
  localparam int WAYS_W  = 4;
  localparam int CFG_A_W = 3;
  localparam int CFG_D_W = 32;

  localparam int IDX_W  = $clog2(WAYS);
  localparam int CNT_W  = $clog2(WAYS + 1);
  localparam int BLK_W  = $clog2(BLOCK);
  localparam int DEPTH  = WAYS * BLOCK;
  localparam int ADDR_W = $clog2(DEPTH);
  // span accumulator: group_start + WAYS * run_length without wrap
  localparam int ACC_W  = POS_W + $clog2(WAYS) + 1;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD = 2'd0,
    OP_INIT = 2'd1,
    OP_NEXT = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [CFG_A_W-1:0] {
    CFG_WAYS    = 3'd0,
    CFG_RUN_LEN = 3'd1,
    CFG_TOTAL   = 3'd2,
    CFG_GROUP   = 3'd3,
    CFG_DESC    = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             load_wr;
    logic             init_start;
    logic             init_step;
    logic             scan_start;
    logic             scan_step;
    logic             finish;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] ways;
    logic             out_free;
  } stat_t;

endpackage

// ----- rtl/kwm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kwm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/kwm_ctrl.sv -----
// Sequencer for the k-way run merge unit: init sweep, run scan, result hand-off.
// Depends on kwm_pkg.
module kwm_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [kwm_pkg::OP_W-1:0]     op,
  input  kwm_pkg::stat_t               stat,
  output kwm_pkg::cmd_t                cmd
);

  kwm_pkg::state_t             state, state_next;
  logic [kwm_pkg::CNT_W-1:0]   cnt, cnt_next;
  logic                        accept;
  kwm_pkg::op_t                op_code;

  assign op_code = kwm_pkg::op_t'(op);
  assign accept  = in_valid && (state == kwm_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kwm_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      kwm_pkg::ST_IDLE: begin
        cnt_next = '0;
        if (accept) begin
          case (op_code)
            kwm_pkg::OP_INIT: state_next = kwm_pkg::ST_INIT;
            kwm_pkg::OP_NEXT: begin
              if (stat.ways == '0) state_next = kwm_pkg::ST_DONE;
              else                 state_next = kwm_pkg::ST_SCAN;
            end
            default: state_next = kwm_pkg::ST_IDLE;
          endcase
        end
      end
      kwm_pkg::ST_INIT: begin
        cnt_next = cnt + kwm_pkg::CNT_W'(1);
        if (cnt == kwm_pkg::CNT_W'(kwm_pkg::WAYS - 1)) state_next = kwm_pkg::ST_IDLE;
      end
      kwm_pkg::ST_SCAN: begin
        cnt_next = cnt + kwm_pkg::CNT_W'(1);
        if (cnt == stat.ways - kwm_pkg::CNT_W'(1)) state_next = kwm_pkg::ST_DRAIN;
      end
      kwm_pkg::ST_DRAIN: state_next = kwm_pkg::ST_DONE;
      kwm_pkg::ST_DONE: begin
        if (stat.out_free) state_next = kwm_pkg::ST_IDLE;
      end
      default: state_next = kwm_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.idx        = cnt[kwm_pkg::IDX_W-1:0];
    case (state)
      kwm_pkg::ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.load_wr    = accept && (op_code == kwm_pkg::OP_LOAD);
        cmd.init_start = accept && (op_code == kwm_pkg::OP_INIT);
        cmd.scan_start = accept && (op_code == kwm_pkg::OP_NEXT);
      end
      kwm_pkg::ST_INIT:  cmd.init_step = 1'b1;
      kwm_pkg::ST_SCAN:  cmd.scan_step = 1'b1;
      kwm_pkg::ST_DRAIN: cmd = cmd;
      kwm_pkg::ST_DONE:  cmd.finish = stat.out_free;
      default:           in_ready = 1'b0;
    endcase
  end

endmodule

// ----- rtl/kwm_datapath.sv -----
// Datapath of the k-way run merge unit: config registers, read positions,
// block cache, two-stage scan compare and the result register.
// Depends on kwm_pkg and kwm_ram.
module kwm_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  kwm_pkg::cmd_t                 cmd,
  output kwm_pkg::stat_t                stat,
  input  logic                          cfg_valid,
  input  logic [kwm_pkg::CFG_A_W-1:0]   cfg_index,
  input  logic [kwm_pkg::CFG_D_W-1:0]   cfg_data,
  input  logic [kwm_pkg::RUN_W-1:0]     run_index,
  input  logic [kwm_pkg::SLOT_W-1:0]    slot,
  input  logic [kwm_pkg::VAL_W-1:0]     element_value,
  input  logic                          res_ready,
  output logic                          res_valid,
  output logic [kwm_pkg::VAL_W-1:0]     out_value,
  output logic [kwm_pkg::RUN_W-1:0]     out_run,
  output logic                          out_valid,
  output logic                          refill_needed
);

  localparam int POS_W = kwm_pkg::POS_W;
  localparam int ACC_W = kwm_pkg::ACC_W;
  localparam int IDX_W = kwm_pkg::IDX_W;
  localparam int ADDR_W = kwm_pkg::ADDR_W;

  logic [kwm_pkg::WAYS_W-1:0] ways_in_use;
  logic [POS_W-1:0]           run_length, total_items, group_start;
  logic                       descending_order;

  logic [POS_W-1:0] positions [kwm_pkg::WAYS];
  logic [ACC_W-1:0] acc;

  // scan stage A (address issued) and stage B (compare)
  logic             cmp_pend;
  logic             a_live;
  logic [IDX_W-1:0] a_run;
  logic [ACC_W-1:0] a_end;
  logic [POS_W-1:0] a_pos;

  logic                      found;
  logic [kwm_pkg::VAL_W-1:0] best_value;
  logic [IDX_W-1:0]          best_run;
  logic [ACC_W-1:0]          best_end;
  logic [POS_W-1:0]          best_pos;

  logic                      ram_we;
  logic [ADDR_W-1:0]         ram_waddr, ram_raddr;
  logic [kwm_pkg::VAL_W-1:0] ram_rdata;

  logic [POS_W-1:0] cur_pos, new_pos;
  logic             cur_empty, better, new_empty, refill_hit;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ways_in_use      <= kwm_pkg::WAYS_W'(8);
      run_length       <= POS_W'(1);
      total_items      <= '0;
      group_start      <= '0;
      descending_order <= 1'b0;
    end else if (cfg_valid) begin
      case (kwm_pkg::cfg_idx_t'(cfg_index))
        kwm_pkg::CFG_WAYS:    ways_in_use      <= cfg_data[kwm_pkg::WAYS_W-1:0];
        kwm_pkg::CFG_RUN_LEN: run_length       <= cfg_data[POS_W-1:0];
        kwm_pkg::CFG_TOTAL:   total_items      <= cfg_data[POS_W-1:0];
        kwm_pkg::CFG_GROUP:   group_start      <= cfg_data[POS_W-1:0];
        kwm_pkg::CFG_DESC:    descending_order <= cfg_data[0];
        default:              ways_in_use      <= ways_in_use;
      endcase
    end
  end

  assign stat.ways = (int'(ways_in_use) > kwm_pkg::WAYS) ?
                     kwm_pkg::CNT_W'(kwm_pkg::WAYS) : kwm_pkg::CNT_W'(ways_in_use);
  assign stat.out_free = !res_valid || res_ready;

  // block cache
  assign ram_we    = cmd.load_wr && (int'(run_index) < kwm_pkg::WAYS) &&
                     (int'(slot) < kwm_pkg::BLOCK);
  assign ram_waddr = ADDR_W'(run_index) * ADDR_W'(kwm_pkg::BLOCK) + ADDR_W'(slot);
  assign cur_pos   = positions[cmd.idx];
  assign ram_raddr = ADDR_W'(cmd.idx) * ADDR_W'(kwm_pkg::BLOCK) +
                     ADDR_W'(cur_pos[kwm_pkg::BLK_W-1:0]);

  kwm_ram #(
    .WIDTH(kwm_pkg::VAL_W),
    .DEPTH(kwm_pkg::DEPTH)
  ) u_cache (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(element_value),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // acc holds the run end (exclusive) for the run being scanned
  assign cur_empty = (cur_pos >= total_items) || (ACC_W'(cur_pos) >= acc);
  assign better    = descending_order ? (ram_rdata > best_value) : (ram_rdata < best_value);

  assign new_pos    = best_pos + POS_W'(1);
  assign new_empty  = (new_pos >= total_items) || (ACC_W'(new_pos) >= best_end);
  assign refill_hit = found && (new_pos[kwm_pkg::BLK_W-1:0] == '0) && !new_empty;

  always_ff @(posedge clk) begin
    if (cmd.init_start) begin
      acc <= ACC_W'(group_start);
    end else if (cmd.scan_start) begin
      acc <= ACC_W'(group_start) + ACC_W'(run_length);
    end else if (cmd.init_step || cmd.scan_step) begin
      acc <= acc + ACC_W'(run_length);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int q = 0; q < kwm_pkg::WAYS; q++) begin
        positions[q] <= '0;
      end
    end else if (cmd.init_step) begin
      positions[cmd.idx] <= (|acc[ACC_W-1:POS_W]) ? '1 : acc[POS_W-1:0];
    end else if (cmd.finish && found) begin
      positions[best_run] <= new_pos;
    end
  end

  // stage A: remember which run was addressed
  always_ff @(posedge clk) begin
    a_live <= !cur_empty;
    a_run  <= cmd.idx;
    a_end  <= acc;
    a_pos  <= cur_pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_pend <= 1'b0;
      found    <= 1'b0;
    end else begin
      cmp_pend <= cmd.scan_step;
      if (cmd.scan_start) begin
        found <= 1'b0;
      end else if (cmp_pend && a_live) begin
        found <= 1'b1;
      end
    end
  end

  // stage B: keep the best front so far; strict compare keeps lowest run on ties
  always_ff @(posedge clk) begin
    if (cmp_pend && a_live && (!found || better)) begin
      best_value <= ram_rdata;
      best_run   <= a_run;
      best_end   <= a_end;
      best_pos   <= a_pos;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.finish) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_value     <= found ? best_value : '0;
      out_run       <= found ? kwm_pkg::RUN_W'(best_run) : '0;
      out_valid     <= found;
      refill_needed <= refill_hit;
    end
  end

endmodule

// ----- rtl/k_way_run_merge_unit.sv -----
// Top level of the k-way run merge unit: controller plus datapath.
// Depends on kwm_pkg, kwm_ctrl, kwm_datapath (and kwm_ram through it).
//
// Merges up to WAYS sorted runs, each with a cached block of BLOCK elements.
// Channels (valid/ready, a transfer when both are high at a clock edge):
//   in_*  : op, run_index, slot, element_value. Load writes one cache
//           element, init sets every run's read position, next emits one
//           merged element. Op code 3 is dropped.
//   res_* : out_value, out_run, out_valid, refill_needed; one result per
//           next item only.
//   cfg_* : register index and data; always ready. Write only while idle.
// Sequence: loads are taken back to back. Init sets one run position per
// cycle from a running group_start + q * run_length sum. A next item
// scans the n active ways: the scan reads one run front per cycle from
// the single-read-port block cache, one compare stage trails the read,
// then the chosen run advances and the result is registered. With n = 0
// the scan is skipped.
// The result register is separate from the input side, so loads and inits
// go on while a result waits; a next item stalls in its last step until
// the receiver takes the previous result.
// Reset (rst, synchronous) clears read positions, config registers to
// their defaults and the result valid; the block cache is not cleared.
module k_way_run_merge_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [kwm_pkg::OP_W-1:0]      op,
  input  logic [kwm_pkg::RUN_W-1:0]     run_index,
  input  logic [kwm_pkg::SLOT_W-1:0]    slot,
  input  logic [kwm_pkg::VAL_W-1:0]     element_value,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [kwm_pkg::VAL_W-1:0]     out_value,
  output logic [kwm_pkg::RUN_W-1:0]     out_run,
  output logic                          out_valid,
  output logic                          refill_needed,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [kwm_pkg::CFG_A_W-1:0]   cfg_index,
  input  logic [kwm_pkg::CFG_D_W-1:0]   cfg_data
);

  kwm_pkg::cmd_t  cmd;
  kwm_pkg::stat_t stat;

  // config writes are always taken
  assign cfg_ready = 1'b1;

  kwm_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op      (op),
    .stat    (stat),
    .cmd     (cmd)
  );

  kwm_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .run_index    (run_index),
    .slot         (slot),
    .element_value(element_value),
    .res_ready    (res_ready),
    .res_valid    (res_valid),
    .out_value    (out_value),
    .out_run      (out_run),
    .out_valid    (out_valid),
    .refill_needed(refill_needed)
  );

endmodule

// ----- verif/tb_k_way_run_merge_unit.sv -----
// Testbench for k_way_run_merge_unit: directed and random merge sessions with an
// in-bench merge predictor, scoreboard and random idling on both channels.
// Depends on kwm_pkg and the RTL under rtl/.
`timescale 1ns / 100ps

module tb_k_way_run_merge_unit;
  import kwm_pkg::*;

  localparam int RANDOM_ITEMS  = 650;
  localparam int SETTLE_CYCLES = 16;      // lets a trailing init finish after its transfer
  localparam int CYCLE_LIMIT   = 400000;

  // One merge result as the block reports it.
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [RUN_W-1:0] run;
    logic             found;
    logic             refill;
  } pick_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  op_t                 op;
  logic [RUN_W-1:0]    run_index;
  logic [SLOT_W-1:0]   slot;
  logic [VAL_W-1:0]    element_value;
  logic                res_valid;
  logic                res_ready;
  logic [VAL_W-1:0]    out_value;
  logic [RUN_W-1:0]    out_run;
  logic                out_valid;
  logic                refill_needed;
  logic                cfg_valid;
  logic                cfg_ready;
  cfg_idx_t            cfg_index;
  logic [CFG_D_W-1:0]  cfg_data;

  k_way_run_merge_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .run_index     (run_index),
    .slot          (slot),
    .element_value (element_value),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .out_value     (out_value),
    .out_run       (out_run),
    .out_valid     (out_valid),
    .refill_needed (refill_needed),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Merge predictor state: cache image, read positions, register copies.
  // ---------------------------------------------------------------------------
  logic [VAL_W-1:0]   cache_img [DEPTH];
  logic [POS_W-1:0]   read_pos  [WAYS];
  logic [WAYS_W-1:0]  reg_ways     = 4'd8;
  logic [POS_W-1:0]   reg_run_len  = 32'd1;
  logic [POS_W-1:0]   reg_total    = '0;
  logic [POS_W-1:0]   reg_group    = '0;
  logic               reg_desc     = 1'b0;

  // Stimulus bookkeeping: which cache entries hold data, and for which position.
  bit                 entry_written [DEPTH];
  bit                 entry_tag_ok  [DEPTH];
  logic [POS_W-1:0]   entry_tag_pos [DEPTH];
  logic [VAL_W-1:0]   data_base;
  bit                 data_desc;

  pick_t              expected_picks [$];
  int                 err_count    = 0;
  int                 fed_items    = 0;
  int                 tx_gap_max   = 8;
  int                 rx_stall_max = 8;
  int                 cycle_count  = 0;

  function automatic int live_ways();
    return (reg_ways > WAYS) ? WAYS : int'(reg_ways);
  endfunction

  // Run is dry at the end of its own span or at the data set total (no wrap).
  function automatic bit run_is_empty(int q);
    logic [63:0] run_end;
    run_end = 64'(reg_group) + 64'(q + 1) * 64'(reg_run_len);
    return (read_pos[q] >= reg_total) || (64'(read_pos[q]) >= run_end);
  endfunction

  function automatic logic [POS_W-1:0] init_pos(int q);
    logic [63:0] p;
    p = 64'(reg_group) + 64'(q) * 64'(reg_run_len);
    return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[POS_W-1:0];
  endfunction

  // Best front over live runs; ties keep the lower run. Advances the winner.
  function automatic pick_t predict_pick();
    pick_t            res;
    int               q;
    int               best;
    bit               found;
    bit               better;
    logic [VAL_W-1:0] v;
    logic [VAL_W-1:0] best_val;
    res      = '0;
    best     = 0;
    found    = 1'b0;
    best_val = '0;
    for (q = 0; q < live_ways(); q++) begin
      if (!run_is_empty(q)) begin
        v = cache_img[q * BLOCK + int'(read_pos[q] % BLOCK)];
        if (!found) begin
          better = 1'b1;
        end else if (reg_desc) begin
          better = v > best_val;
        end else begin
          better = v < best_val;
        end
        if (better) begin
          best     = q;
          best_val = v;
          found    = 1'b1;
        end
      end
    end
    if (found) begin
      read_pos[best] = read_pos[best] + 1'b1;
      res.value  = best_val;
      res.run    = RUN_W'(best);
      res.found  = 1'b1;
      res.refill = (read_pos[best] % BLOCK == 0) && !run_is_empty(best);
    end
    return res;
  endfunction

  function automatic void apply_item(op_t o, logic [RUN_W-1:0] r, logic [SLOT_W-1:0] s,
                                     logic [VAL_W-1:0] v);
    int q;
    case (o)
      OP_LOAD: begin
        cache_img[int'(r) * BLOCK + int'(s)] = v;
      end
      OP_INIT: begin
        for (q = 0; q < WAYS; q++) read_pos[q] = init_pos(q);
      end
      OP_NEXT: begin
        expected_picks.push_back(predict_pick());
      end
      default: ;  // op code 3 is dropped
    endcase
  endfunction

  // Sorted run content: offset within the run in the middle bits, so runs tie
  // when they sit at the same offset and draw the same low bits.
  function automatic logic [VAL_W-1:0] run_data(int q, logic [POS_W-1:0] pos);
    logic [POS_W-1:0] offs;
    logic [VAL_W-1:0] v;
    offs = pos - (reg_group + 32'(q) * reg_run_len);
    v    = {data_base[63:34], offs, 2'($urandom_range(0, 3))};
    return data_desc ? ~v : v;
  endfunction

  // ---------------------------------------------------------------------------
  // Input channel driver. Valid stays high after a transfer; the next call
  // either reuses it (no gap) or lowers it, so each step sees one assignment.
  // ---------------------------------------------------------------------------
  task automatic push_item(op_t o, logic [RUN_W-1:0] r, logic [SLOT_W-1:0] s,
                           logic [VAL_W-1:0] v);
    int gap;
    int e;
    gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    op            <= o;
    run_index     <= r;
    slot          <= s;
    element_value <= v;
    @(negedge clk);
    while (in_ready !== 1'b1) @(negedge clk);
    @(posedge clk);
    apply_item(o, r, s, v);
    if (o == OP_LOAD) begin
      e = int'(r) * BLOCK + int'(s);
      entry_written[e] = 1'b1;
      entry_tag_ok[e]  = 1'b0;
    end
    if (o != OP_NONE) fed_items++;
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_D_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(negedge clk);
    while (cfg_ready !== 1'b1) @(negedge clk);
    @(posedge clk);
    case (idx)
      CFG_WAYS:    reg_ways    = d[WAYS_W-1:0];
      CFG_RUN_LEN: reg_run_len = d;
      CFG_TOTAL:   reg_total   = d;
      CFG_GROUP:   reg_group   = d;
      CFG_DESC:    reg_desc    = d[0];
      default: ;
    endcase
  endtask

  // Only called with the block idle.
  task automatic write_config(logic [WAYS_W-1:0] w, logic [POS_W-1:0] rl,
                              logic [POS_W-1:0] tot, logic [POS_W-1:0] gs, bit d);
    write_reg(CFG_WAYS, CFG_D_W'(w));
    write_reg(CFG_RUN_LEN, rl);
    write_reg(CFG_TOTAL, tot);
    write_reg(CFG_GROUP, gs);
    write_reg(CFG_DESC, CFG_D_W'(d));
    cfg_valid <= 1'b0;
  endtask

  // Drain: no valid, all results back, then let a trailing init finish.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_picks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Load the front entry of run q unless it already holds that position's data.
  // Now and then a stale (but written) entry is left in place.
  task automatic feed_front(int q);
    logic [POS_W-1:0] p;
    int               e;
    p = read_pos[q];
    e = q * BLOCK + int'(p % BLOCK);
    if (!entry_written[e] ||
        (!(entry_tag_ok[e] && entry_tag_pos[e] == p) && $urandom_range(0, 9) != 0)) begin
      push_item(OP_LOAD, RUN_W'(q), p[BLK_W-1:0], run_data(q, p));
      entry_tag_ok[e]  = 1'b1;
      entry_tag_pos[e] = p;
    end
  endtask

  // One merge request with every live front loaded first: no never-written
  // entry is ever read.
  task automatic merge_step();
    int q;
    for (q = 0; q < live_ways(); q++) begin
      if (!run_is_empty(q)) feed_front(q);
    end
    push_item(OP_NEXT, RUN_W'($urandom), SLOT_W'($urandom), {$urandom, $urandom});
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, transfer seen at negedge, checked at posedge.
  // ---------------------------------------------------------------------------
  initial begin : result_checker
    int    stall;
    pick_t got;
    pick_t want;
    res_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = (rx_stall_max == 0) ? 0 : $urandom_range(0, rx_stall_max);
      if (stall > 0) begin
        res_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ready <= 1'b1;
      @(negedge clk);
      while (res_valid !== 1'b1) @(negedge clk);
      got = {out_value, out_run, out_valid, refill_needed};
      @(posedge clk);
      if (expected_picks.size() == 0) begin
        $error("result transfer with no merge request pending");
        err_count++;
      end else begin
        want = expected_picks.pop_front();
        if (got.value !== want.value) begin
          $error("out_value: expected %h, actual %h", want.value, got.value);
          err_count++;
        end
        if (got.run !== want.run) begin
          $error("out_run: expected %0d, actual %0d", want.run, got.run);
          err_count++;
        end
        if (got.found !== want.found) begin
          $error("out_valid: expected %0b, actual %0b", want.found, got.found);
          err_count++;
        end
        if (got.refill !== want.refill) begin
          $error("refill_needed: expected %0b, actual %0b", want.refill, got.refill);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Defaults: total 0 leaves every run dry. Op code 3 must be dropped.
  task automatic test_reset_state();
    push_item(OP_NEXT, '0, '0, '0);
    push_item(OP_NONE, '1, '1, '1);
  endtask

  // Equal fronts go to the lower run; then largest-first ordering.
  task automatic test_tie_break();
    wait_idle();
    data_base = {$urandom, $urandom};
    data_desc = 1'b0;
    write_config(4'd4, 32'd16, 32'd64, 32'd0, 1'b0);
    push_item(OP_INIT, '0, '0, '0);
    push_item(OP_LOAD, 3'd0, 4'd0, 64'd7);
    push_item(OP_LOAD, 3'd1, 4'd0, 64'd7);
    push_item(OP_LOAD, 3'd2, 4'd0, 64'd9);
    push_item(OP_LOAD, 3'd3, 4'd0, '1);
    push_item(OP_NEXT, '0, '0, '0);   // tie between runs 0 and 1
    merge_step();
    wait_idle();
    write_config(4'd4, 32'd16, 32'd64, 32'd0, 1'b1);
    merge_step();
  endtask

  // Single run starting two short of a block edge: second pick crosses it.
  // Then zero ways in use gives an empty result.
  task automatic test_block_refill();
    wait_idle();
    write_config(4'd1, 32'd20, 32'd40, 32'd14, 1'b0);
    push_item(OP_INIT, '0, '0, '0);
    merge_step();
    merge_step();
    wait_idle();
    write_config(4'd0, 32'd20, 32'd40, 32'd14, 1'b0);
    push_item(OP_NEXT, '0, '0, '0);
  endtask

  // Ways above WAYS saturate; start positions past 32 bits saturate and run dry.
  task automatic test_saturation_extremes();
    wait_idle();
    write_config(4'd15, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0);
    push_item(OP_INIT, '0, '0, '0);
    push_item(OP_LOAD, 3'd7, 4'd15, 64'd0);
    push_item(OP_LOAD, 3'd0, 4'd14, '1);
    push_item(OP_NEXT, '0, '0, '0);
    push_item(OP_NEXT, '1, '1, '1);
  endtask

  task automatic random_session();
    logic [WAYS_W-1:0] w;
    logic [POS_W-1:0]  rl;
    logic [POS_W-1:0]  tot;
    logic [POS_W-1:0]  gs;
    bit                d;
    int                n;
    int                steps;
    int                i;
    case ($urandom_range(0, 9))
      0:       w = 4'd0;
      1, 2:    w = WAYS_W'($urandom_range(9, 15));
      default: w = WAYS_W'($urandom_range(1, 8));
    endcase
    n = (w > WAYS) ? WAYS : int'(w);
    d = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 3) != 0) begin
      // well-formed group, maybe with a short tail
      rl  = $urandom_range(1, 24);
      gs  = $urandom_range(0, 64);
      tot = gs + 32'(n) * rl;
      if ($urandom_range(0, 1) == 1) tot = tot - $urandom_range(0, rl - 1);
    end else begin
      case ($urandom_range(0, 2))
        0:       rl = 32'hFFFF_FFFF;
        1:       rl = $urandom;
        default: rl = $urandom_range(1, 40);
      endcase
      if (rl == 0) rl = 32'd1;
      case ($urandom_range(0, 2))
        0:       gs = 32'hFFFF_FFFF - $urandom_range(0, 40);
        1:       gs = $urandom;
        default: gs = 32'd0;
      endcase
      case ($urandom_range(0, 3))
        0:       tot = 32'hFFFF_FFFF;
        1:       tot = $urandom;
        2:       tot = 32'd0;
        default: tot = gs + $urandom_range(0, 100);
      endcase
    end
    case ($urandom_range(0, 4))
      0: begin
        tx_gap_max   = 0;
        rx_stall_max = 0;
      end
      1: begin
        tx_gap_max   = 0;
        rx_stall_max = 8;
      end
      2: begin
        tx_gap_max   = 8;
        rx_stall_max = 0;
      end
      default: begin
        tx_gap_max   = 8;
        rx_stall_max = 8;
      end
    endcase
    wait_idle();
    data_base = {$urandom, $urandom};
    data_desc = ($urandom_range(0, 4) == 0) ? ~d : d;
    write_config(w, rl, tot, gs, d);
    push_item(OP_INIT, RUN_W'($urandom), SLOT_W'($urandom), {$urandom, $urandom});
    steps = $urandom_range(8, 45);
    for (i = 0; i < steps; i++) begin
      case ($urandom_range(0, 19))
        0: push_item(OP_LOAD, RUN_W'($urandom), SLOT_W'($urandom), {$urandom, $urandom});
        1: push_item(OP_NONE, RUN_W'($urandom), SLOT_W'($urandom), {$urandom, $urandom});
        2: push_item(OP_INIT, RUN_W'($urandom), SLOT_W'($urandom), {$urandom, $urandom});
        default: merge_step();
      endcase
    end
  endtask

  task automatic test_random_merge();
    int start;
    start = fed_items;
    while (fed_items - start < RANDOM_ITEMS) random_session();
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    op            = OP_NONE;
    run_index     = '0;
    slot          = '0;
    element_value = '0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_WAYS;
    cfg_data      = '0;
    data_base     = '0;
    data_desc     = 1'b0;
    for (int q = 0; q < WAYS; q++) read_pos[q] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_tie_break();
    test_block_refill();
    test_saturation_extremes();
    test_random_merge();

    wait_idle();
    if (err_count == 0 && expected_picks.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
